// ----- hdl/json_string_escaper_assert.svh -----
// Assertion macros shared by the JSON string escaper RTL.
`ifndef JSON_STRING_ESCAPER_ASSERT_SVH
`define JSON_STRING_ESCAPER_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define JSE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define JSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- hdl/jse_pkg.sv -----
// Types and constants shared by the JSON string escaper modules.
`timescale 1ns / 1ps
package jse_pkg;

  // Escape class of one input byte.
  typedef enum logic [1:0] {
    KIND_PLAIN   = 2'd0,
    KIND_SHORT   = 2'd1,
    KIND_UNICODE = 2'd2
  } jse_kind_e;

  // Closing status codes.
  localparam logic [1:0] ST_FITS       = 2'd0;
  localparam logic [1:0] ST_OVER_CAP   = 2'd1;
  localparam logic [1:0] ST_OVER_LIMIT = 2'd2;

  // Characters used in the escaped literal.
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U = 8'h75;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;

  // Size bookkeeping.
  localparam int unsigned SizeW = 17;
  localparam logic [SizeW-1:0] SIZE_QUOTES = 17'd2;
  localparam logic [SizeW-1:0] SIZE_SAT = 17'h10000;

  // One classified item handed from the front to the back.
  typedef struct packed {
    logic        need_open;
    logic        has_byte;
    jse_kind_e   kind;
    logic [7:0]  chr;
    logic        close;
    logic [1:0]  status;
    logic [15:0] total;
  } jse_job_t;

endpackage

// ----- hdl/jse_front.sv -----
// Front end: accepts input beats, classifies bytes and tracks literal size.
`timescale 1ns / 1ps
module jse_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        byte_i,
  input  logic              present_i,
  input  logic              eos_i,
  input  logic              q_full_i,
  output logic              push_o,
  output jse_pkg::jse_job_t job_o
);
  import jse_pkg::*;

  logic [15:0]      cap_q;
  logic             inside_q, inside_d;
  logic [SizeW-1:0] size_q, size_d;

  jse_kind_e        kind;
  logic [7:0]       chr;
  logic [2:0]       n_bytes;
  logic [SizeW-1:0] base, sum, sat;
  logic             over;
  logic             accept, useful;

  // Capacity register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= 16'hFFFF;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // Classify the byte.
  always_comb begin
    kind = KIND_PLAIN;
    chr  = byte_i;
    unique case (byte_i)
      8'h22: begin kind = KIND_SHORT; chr = CH_QUOTE; end
      8'h5C: begin kind = KIND_SHORT; chr = CH_BSLASH; end
      8'h08: begin kind = KIND_SHORT; chr = 8'h62; end
      8'h0C: begin kind = KIND_SHORT; chr = 8'h66; end
      8'h0A: begin kind = KIND_SHORT; chr = 8'h6E; end
      8'h0D: begin kind = KIND_SHORT; chr = 8'h72; end
      8'h09: begin kind = KIND_SHORT; chr = 8'h74; end
      default: begin
        if (byte_i < 8'h20) begin
          kind = KIND_UNICODE;
        end
      end
    endcase
  end

  // Escaped length of this item and the saturating running size.
  always_comb begin
    n_bytes = 3'd0;
    if (present_i) begin
      unique case (kind)
        KIND_PLAIN:   n_bytes = 3'd1;
        KIND_SHORT:   n_bytes = 3'd2;
        KIND_UNICODE: n_bytes = 3'd6;
        default:      n_bytes = 3'd1;
      endcase
    end
    base = inside_q ? size_q : SIZE_QUOTES;
    sum  = base + {{(SizeW-3){1'b0}}, n_bytes};
    over = sum[SizeW-1];
    sat  = over ? SIZE_SAT : sum;
  end

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign useful     = present_i || eos_i;
  assign push_o     = accept && useful;

  // Build the job for the back end.
  always_comb begin
    job_o.need_open = !inside_q;
    job_o.has_byte  = present_i;
    job_o.kind      = kind;
    job_o.chr       = chr;
    job_o.close     = eos_i;
    if (over) begin
      job_o.status = ST_OVER_LIMIT;
      job_o.total  = 16'd0;
    end else begin
      job_o.status = (sum[15:0] > cap_q) ? ST_OVER_CAP : ST_FITS;
      job_o.total  = sum[15:0];
    end
  end

  // Advance the literal state; an item with neither byte nor end changes nothing.
  always_comb begin
    inside_d = inside_q;
    size_d   = size_q;
    if (accept && useful) begin
      if (eos_i) begin
        inside_d = 1'b0;
        size_d   = SIZE_QUOTES;
      end else begin
        inside_d = 1'b1;
        size_d   = sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      size_q   <= SIZE_QUOTES;
    end else begin
      inside_q <= inside_d;
      size_q   <= size_d;
    end
  end

endmodule

// ----- hdl/jse_queue.sv -----
// Short job queue between the front and back ends.
`timescale 1ns / 1ps
module jse_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  jse_pkg::jse_job_t job_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output jse_pkg::jse_job_t job_o
);
  import jse_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  jse_job_t        slot_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign job_o   = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers and fill count.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the payload.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= job_i;
    end
  end

endmodule

// ----- hdl/jse_back.sv -----
// Back end: expands one job into its escaped output bytes, one per beat.
`timescale 1ns / 1ps
module jse_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  jse_pkg::jse_job_t job_i,
  output logic              pop_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output logic [7:0]        m_byte_o,
  output logic              m_last_o,
  output logic              m_done_o,
  output logic [1:0]        m_status_o,
  output logic [15:0]       m_total_o
);
  import jse_pkg::*;

  logic [2:0]  step_q, step_d;
  logic        valid_q;
  logic [7:0]  byte_q, byte_d;
  logic        last_q, done_d, done_q;
  logic [1:0]  status_q, status_d;
  logic [15:0] total_q, total_d;

  logic [2:0]  blen, j, len_m1;
  logic [3:0]  len;
  logic [7:0]  seq_byte;
  logic        adv, emit, last;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = CH_ZERO + {4'd0, nib};
    end else begin
      r = CH_UPPER_A + {4'd0, nib} - 8'd10;
    end
    return r;
  endfunction

  // Length of the byte part and of the whole job.
  always_comb begin
    blen = 3'd0;
    if (job_i.has_byte) begin
      unique case (job_i.kind)
        KIND_PLAIN:   blen = 3'd1;
        KIND_SHORT:   blen = 3'd2;
        KIND_UNICODE: blen = 3'd6;
        default:      blen = 3'd1;
      endcase
    end
    len    = {3'd0, job_i.need_open} + {1'b0, blen} + {3'd0, job_i.close};
    len_m1 = 3'(len - 4'd1);
    j      = step_q - {2'd0, job_i.need_open};
    last   = (step_q == len_m1);
  end

  // Pick the byte of the escape sequence at position j.
  always_comb begin
    seq_byte = job_i.chr;
    unique case (job_i.kind)
      KIND_PLAIN: seq_byte = job_i.chr;
      KIND_SHORT: seq_byte = (j == 3'd0) ? CH_BSLASH : job_i.chr;
      KIND_UNICODE: begin
        unique case (j)
          3'd0:       seq_byte = CH_BSLASH;
          3'd1:       seq_byte = CH_U;
          3'd2, 3'd3: seq_byte = CH_ZERO;
          3'd4:       seq_byte = hex_char(job_i.chr[7:4]);
          default:    seq_byte = hex_char(job_i.chr[3:0]);
        endcase
      end
      default: seq_byte = job_i.chr;
    endcase
  end

  // Select the beat: opening quote, escaped byte, then closing quote.
  always_comb begin
    byte_d   = CH_QUOTE;
    done_d   = 1'b0;
    status_d = ST_FITS;
    total_d  = 16'd0;
    if (job_i.need_open && step_q == 3'd0) begin
      byte_d = CH_QUOTE;
    end else if (job_i.has_byte && j < blen) begin
      byte_d = seq_byte;
    end else begin
      byte_d   = CH_QUOTE;
      done_d   = 1'b1;
      status_d = job_i.status;
      total_d  = job_i.total;
    end
  end

  assign adv    = !valid_q || m_ready_i;
  assign emit   = adv && job_valid_i;
  assign pop_o  = emit && last;
  assign step_d = pop_o ? 3'd0 : (emit ? step_q + 3'd1 : step_q);

  // Output register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      step_q  <= 3'd0;
    end else begin
      step_q <= step_d;
      if (adv) begin
        valid_q <= job_valid_i;
      end
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q   <= byte_d;
      last_q   <= last;
      done_q   <= done_d;
      status_q <= status_d;
      total_q  <= total_d;
    end
  end

  assign m_valid_o  = valid_q;
  assign m_byte_o   = byte_q;
  assign m_last_o   = last_q;
  assign m_done_o   = done_q;
  assign m_status_o = status_q;
  assign m_total_o  = total_q;

endmodule

// ----- hdl/json_string_escaper.sv -----
// Top level of the JSON string escaper.
`timescale 1ns / 1ps
// Streams raw string bytes in and a JSON string literal out: an opening quote
// before the first byte, escapes for quote, backslash, b f n r t and \u00XX for
// other control bytes, and a closing quote on the beat with tlast set at the
// input. The closing quote beat carries literal_done, the escaped size with
// quotes, and a status (fits, over capacity, over 65535); dropping a literal
// that does not fit is up to the consumer. Output runs at one byte per clock while
// the consumer is ready and a job is queued; an item produces up to eight bytes,
// each sent through the single byte-wide output register of the
// expansion stage. The input side takes one beat a cycle while the job queue
// of QueueDepth entries has room, so it runs ahead of a stalled output.
`include "json_string_escaper_assert.svh"
module json_string_escaper #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,        // capacity
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,     // [7:0] byte_value
  input  logic [0:0]  s_axis_tuser_i,     // [0] byte_present
  input  logic        s_axis_tlast_i,     // end_of_string
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,     // [7:0] out_byte, [23:8] total_size
  output logic [2:0]  m_axis_tuser_o,     // [0] literal_done, [2:1] status
  output logic        m_axis_tlast_o      // last_of_run
);
  import jse_pkg::*;

  jse_job_t   push_job, head_job;
  logic       push, q_full, q_valid, pop;
  logic [7:0] out_byte;
  logic       out_done;
  logic [1:0] out_status;
  logic [15:0] out_total;

  // Accept and classify.
  jse_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .byte_i      (s_axis_tdata_i),
    .present_i   (s_axis_tuser_i[0]),
    .eos_i       (s_axis_tlast_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .job_o       (push_job)
  );

  // Decouple front and back.
  jse_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (head_job)
  );

  // Expand into output beats.
  jse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .m_byte_o    (out_byte),
    .m_last_o    (m_axis_tlast_o),
    .m_done_o    (out_done),
    .m_status_o  (out_status),
    .m_total_o   (out_total)
  );

  assign m_axis_tdata_o = {out_total, out_byte};
  assign m_axis_tuser_o = {out_status, out_done};

  // Closing quote always ends the run of its item.
  `JSE_ASSERT_SAME(a_done_is_last, clk_i, rst_ni, m_axis_tvalid_o && out_done,
                   m_axis_tlast_o && out_byte == CH_QUOTE)
  // Size and status appear only on the closing quote.
  `JSE_ASSERT_SAME(a_meta_on_close, clk_i, rst_ni, m_axis_tvalid_o && !out_done,
                   out_status == ST_FITS && out_total == 16'd0)
  // Overflowed literal reports no size; otherwise the size counts both quotes.
  `JSE_ASSERT_SAME(a_total_consistent, clk_i, rst_ni, m_axis_tvalid_o && out_done,
                   (out_status == ST_OVER_LIMIT && out_total == 16'd0) ||
                   (out_status != ST_OVER_LIMIT && out_total >= 16'd2))
  // Queue never accepts while full, so input ready drops with a full queue.
  `JSE_ASSERT_SAME(a_ready_vs_full, clk_i, rst_ni, q_full, !s_axis_tready_o)

endmodule

// ----- test/json_string_escaper_tb.sv -----
// Self-checking testbench for the JSON string escaper.
`timescale 1ns / 1ps
module json_string_escaper_tb;
  import jse_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned HoldOffAfter = 120;
  localparam logic [SizeW-1:0] SizeMax = 17'd65535;

  typedef logic [7:0] byte_t;

  // One raw string byte waiting to be sent, with its lead-in gap.
  typedef struct {
    byte_t value;
    logic  present;
    logic  eos;
    int    gap;
  } pend_t;

  // One escaped output byte as it should leave the block.
  typedef struct {
    byte_t       out_byte;
    logic [15:0] total;
    logic        done;
    logic [1:0]  status;
    logic        last;
  } esc_beat_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = 16'd0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'd0;     // [7:0] byte_value
  logic [0:0]  s_axis_tuser_i = 1'b0;     // [0] byte_present
  logic        s_axis_tlast_i = 1'b0;     // end_of_string
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;            // [7:0] out_byte, [23:8] total_size
  logic [2:0]  m_axis_tuser_o;            // [0] literal_done, [2:1] status
  logic        m_axis_tlast_o;            // last_of_run

  json_string_escaper uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  pend_t     pending_bytes[$];
  esc_beat_t escaped_beats[$];
  pend_t     cur_byte;

  // Predictor copy of the block state and register.
  logic             in_literal = 1'b0;
  logic [SizeW-1:0] esc_size = SIZE_QUOTES;
  logic [15:0]      capacity_reg = 16'hFFFF;

  logic        offering = 1'b0;
  int          gap_cnt = 0;
  int          rdy_wait = 0;
  int          items_accepted = 0;
  int          hold_cnt = 0;
  logic        hold_fired = 1'b0;
  logic        calm = 1'b0;
  int          items_made = 0;
  int          fail_count = 0;
  int unsigned cycle_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic byte_t hex_digit(logic [3:0] nib);
    return (nib < 4'd10) ? CH_ZERO + byte_t'(nib) : CH_UPPER_A + byte_t'(nib - 4'd10);
  endfunction

  function automatic esc_beat_t make_beat(byte_t b, logic done, logic [1:0] st,
                                          logic [15:0] total);
    esc_beat_t r;
    r.out_byte = b;
    r.done = done;
    r.status = st;
    r.total = total;
    r.last = 1'b0;
    return r;
  endfunction

  // Work out the escaped bytes one accepted string byte produces.
  task automatic escape_predict(input pend_t it);
    esc_beat_t   run[8];
    int          n;
    byte_t       sc;
    int          seq_len;
    logic [1:0]  st;
    logic [15:0] total;
    n = 0;
    if (!it.present && !it.eos) return;
    if (!in_literal) begin
      run[n] = make_beat(CH_QUOTE, 1'b0, ST_FITS, 16'd0);
      n = n + 1;
      in_literal = 1'b1;
      esc_size = SIZE_QUOTES;
    end
    if (it.present) begin
      sc = 8'h00;
      case (it.value)
        8'h22: sc = CH_QUOTE;
        8'h5C: sc = CH_BSLASH;
        8'h08: sc = "b";
        8'h0C: sc = "f";
        8'h0A: sc = "n";
        8'h0D: sc = "r";
        8'h09: sc = "t";
        default: sc = 8'h00;
      endcase
      if (sc != 8'h00) begin
        run[n] = make_beat(CH_BSLASH, 1'b0, ST_FITS, 16'd0);
        run[n+1] = make_beat(sc, 1'b0, ST_FITS, 16'd0);
        seq_len = 2;
      end else if (it.value < 8'h20) begin
        run[n] = make_beat(CH_BSLASH, 1'b0, ST_FITS, 16'd0);
        run[n+1] = make_beat(CH_U, 1'b0, ST_FITS, 16'd0);
        run[n+2] = make_beat(CH_ZERO, 1'b0, ST_FITS, 16'd0);
        run[n+3] = make_beat(CH_ZERO, 1'b0, ST_FITS, 16'd0);
        run[n+4] = make_beat(hex_digit(it.value[7:4]), 1'b0, ST_FITS, 16'd0);
        run[n+5] = make_beat(hex_digit(it.value[3:0]), 1'b0, ST_FITS, 16'd0);
        seq_len = 6;
      end else begin
        run[n] = make_beat(it.value, 1'b0, ST_FITS, 16'd0);
        seq_len = 1;
      end
      n = n + seq_len;
      // Saturate once the literal no longer fits in 16 bits.
      esc_size = esc_size + SizeW'(seq_len);
      if (esc_size > SizeMax) esc_size = SIZE_SAT;
    end
    if (it.eos) begin
      if (esc_size > SizeMax) begin
        st = ST_OVER_LIMIT;
        total = 16'd0;
      end else begin
        st = (esc_size > SizeW'(capacity_reg)) ? ST_OVER_CAP : ST_FITS;
        total = esc_size[15:0];
      end
      run[n] = make_beat(CH_QUOTE, 1'b1, st, total);
      n = n + 1;
      in_literal = 1'b0;
      esc_size = SIZE_QUOTES;
    end
    run[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) escaped_beats.push_back(run[i]);
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Present string bytes from the pending queue, predict on each accepted beat.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      offering = 1'b0;
      gap_cnt = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        escape_predict(cur_byte);
        offering = 1'b0;
        items_accepted <= items_accepted + 1;
      end
      if (!offering && pending_bytes.size() != 0) begin
        if (gap_cnt < pending_bytes[0].gap) begin
          gap_cnt++;
        end else begin
          cur_byte = pending_bytes.pop_front();
          offering = 1'b1;
          gap_cnt = 0;
          s_axis_tdata_i <= cur_byte.value;
          s_axis_tuser_i <= cur_byte.present;
          s_axis_tlast_i <= cur_byte.eos;
        end
      end
      s_axis_tvalid_i <= offering;
    end
  end

  // Hold off the output once, long enough to back the block up to its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt <= 0;
      hold_fired <= 1'b0;
    end else if (!hold_fired && items_accepted >= HoldOffAfter) begin
      hold_fired <= 1'b1;
      hold_cnt <= HoldOffCycles;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // Accept escaped beats with random stalls and compare against the prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      rdy_wait = 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (escaped_beats.size() == 0) begin
          $display("%0t: unexpected beat, expected none actual %0h/%0h/%0b", $time,
                   m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
          fail_count++;
        end else begin
          check_field("out_byte", escaped_beats[0].out_byte, m_axis_tdata_o[7:0]);
          check_field("total_size", escaped_beats[0].total, m_axis_tdata_o[23:8]);
          check_field("literal_done", escaped_beats[0].done, m_axis_tuser_o[0]);
          check_field("status", escaped_beats[0].status, m_axis_tuser_o[2:1]);
          check_field("last_of_run", escaped_beats[0].last, m_axis_tlast_o);
          void'(escaped_beats.pop_front());
        end
        rdy_wait = calm ? 0 : $urandom_range(0, 13);
      end else if (rdy_wait != 0) begin
        rdy_wait--;
      end
      m_axis_tready_i <= (rdy_wait == 0) && (hold_cnt == 0);
    end
  end

  // Stop a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic push_item(byte_t value, logic present, logic eos);
    pend_t it;
    it.value = value;
    it.present = present;
    it.eos = eos;
    it.gap = calm ? 0 : $urandom_range(0, 13);
    pending_bytes.push_back(it);
  endtask

  // Queue one string of random length and content, with stray empty items.
  task automatic queue_random_string();
    int    len;
    int    r;
    byte_t v;
    len = $urandom_range(0, 12);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0) push_item(byte_t'($urandom_range(0, 255)), 1'b0, 1'b0);
      r = $urandom_range(0, 9);
      if (r < 3) v = byte_t'($urandom_range(0, 8'h1F));
      else if (r == 3) v = CH_QUOTE;
      else if (r == 4) v = CH_BSLASH;
      else v = byte_t'($urandom_range(1, 255));
      items_made++;
      if (i == len - 1 && $urandom_range(0, 1) == 1) begin
        push_item(v, 1'b1, 1'b1);
        return;
      end
      push_item(v, 1'b1, 1'b0);
    end
    items_made++;
    push_item(byte_t'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (pending_bytes.size() != 0 || offering || escaped_beats.size() != 0)
      @(negedge clk_i);
  endtask

  // Write capacity once everything in flight has drained.
  task automatic write_capacity(logic [15:0] value);
    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    capacity_reg = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_strings(logic [15:0] cap, int count, logic quiet);
    int stop_at;
    write_capacity(cap);
    calm = quiet;
    stop_at = items_made + count;
    while (items_made < stop_at) queue_random_string();
    wait_idle();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty item, empty string, then every escape class and byte extreme.
    push_item(8'hA5, 1'b0, 1'b0);
    push_item(8'h5A, 1'b0, 1'b1);
    push_item(8'h00, 1'b1, 1'b0);
    push_item(8'h01, 1'b1, 1'b0);
    push_item(8'h1F, 1'b1, 1'b0);
    push_item(8'h20, 1'b1, 1'b0);
    push_item(CH_QUOTE, 1'b1, 1'b0);
    push_item(CH_BSLASH, 1'b1, 1'b0);
    push_item(8'h08, 1'b1, 1'b0);
    push_item(8'h0C, 1'b1, 1'b0);
    push_item(8'hFF, 1'b0, 1'b0);
    push_item(8'h0A, 1'b1, 1'b0);
    push_item(8'h0D, 1'b1, 1'b0);
    push_item(8'h09, 1'b1, 1'b0);
    push_item(8'h7F, 1'b1, 1'b0);
    push_item(8'h80, 1'b1, 1'b0);
    push_item(8'hFF, 1'b1, 1'b0);
    push_item(8'h41, 1'b1, 1'b0);
    push_item(8'h5A, 1'b1, 1'b1);
    push_item(8'h1B, 1'b1, 1'b1);
    items_made = 20;
    wait_idle();

    // Random literals across capacity settings, the extremes included.
    random_strings(16'd0, 90, 1'b0);
    random_strings(16'hFFFF, 90, 1'b0);
    random_strings(16'($urandom_range(2, 40)), 90, 1'b0);
    random_strings(16'($urandom_range(0, 65535)), 80, 1'b1);
    random_strings(16'($urandom_range(2, 30)), 90, 1'b0);

    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
